/* design/rdlm_pkg.sv */
// rdlm_pkg: widths, constants, register indexes and the controller/datapath
// command and status types of the dBFS level meter
// no dependencies
`timescale 1ns / 1ps

package rdlm_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int SQ_W       = 31;                 // a square is at most 2^30
  localparam int SUM_W      = 47;
  localparam int CNT_W      = 16;
  localparam int EXP_W      = 6;
  localparam int FRAC_W     = 16;
  localparam int LOG_W      = EXP_W + FRAC_W;
  localparam int MAN_W      = 31;                 // mantissa in [2^30, 2^31)
  localparam int K_W        = 26;
  localparam int PROD_W     = LOG_W + K_W;
  localparam int R_W        = PROD_W + 1 - 32;    // rounded product, 1/256 dB
  localparam int LEVEL_W    = 16;
  localparam int BAR_W      = 7;
  localparam int FLOOR_W    = 8;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int ITR_W      = 4;

  localparam logic [EXP_W-1:0]  EXP_TOP     = 6'd46;
  localparam logic [LOG_W:0]    LOG_OFFSET  = {7'd30, 16'd0};   // 30.0 in q16
  localparam logic [K_W-1:0]    DB_PER_LOG2 = 26'd50504453;     // 10*log10(2) in q24
  localparam logic [PROD_W:0]   RND_HALF    = {{(PROD_W-31){1'b0}}, 1'b1, 31'd0};
  localparam logic [ITR_W-1:0]  SQR_LAST_ITR = 4'd15;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_DB   = 4'd1;

  localparam logic [CNT_W-1:0]   WINDOW_LEN_RST = 16'd1470;
  localparam logic [FLOOR_W-1:0] FLOOR_DB_RST   = 8'hC4;        // -60 dB

  typedef struct packed {
    logic acc;          // sample transfer
    logic ld_sum;       // start normalising the sum
    logic norm_shift;
    logic man_load;
    logic sqr_step;
    logic ld_cnt;       // keep log of sum, start normalising the count
    logic scale;
    logic set_level;
    logic silent;
    logic div_init;
    logic div_step;
    logic finish;       // load output register, clear window
  } cmd_t;

  typedef struct packed {
    logic last;
    logic sum_zero;
    logic norm_top;
  } status_t;

endpackage

/* design/rdlm_ctrl.sv */
// rdlm_ctrl: sequencer of the level meter, accumulation then the window-end
// log, scale, clamp and meter division; uses rdlm_pkg
`timescale 1ns / 1ps

module rdlm_ctrl import rdlm_pkg::*; #(
  parameter int DivSteps = 5
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_ACCUM,
    ST_ADD,
    ST_CHECK,
    ST_NORM_S,
    ST_SQR_S,
    ST_LD_CNT,
    ST_NORM_C,
    ST_SQR_C,
    ST_SCALE,
    ST_LEVEL,
    ST_DIV_INIT,
    ST_DIV,
    ST_DONE
  } state_t;

  localparam logic [ITR_W-1:0] DIV_LAST_ITR = ITR_W'(DivSteps - 1);

  state_t           state_r, state_nxt;
  logic [ITR_W-1:0] itr_r, itr_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    itr_nxt   = itr_r;
    case (state_r)
      ST_ACCUM: begin
        cmd.acc = in_valid;
        if (in_valid && status.last) begin
          state_nxt = ST_ADD;
        end
      end
      // last square still on its way into the sum
      ST_ADD: begin
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (status.sum_zero) begin
          cmd.set_level = 1'b1;
          cmd.silent    = 1'b1;
          state_nxt     = ST_DIV_INIT;
        end else begin
          cmd.ld_sum = 1'b1;
          state_nxt  = ST_NORM_S;
        end
      end
      ST_NORM_S: begin
        if (status.norm_top) begin
          cmd.man_load = 1'b1;
          itr_nxt      = SQR_LAST_ITR;
          state_nxt    = ST_SQR_S;
        end else begin
          cmd.norm_shift = 1'b1;
        end
      end
      ST_SQR_S: begin
        cmd.sqr_step = 1'b1;
        if (itr_r == '0) begin
          state_nxt = ST_LD_CNT;
        end else begin
          itr_nxt = itr_r - 1'b1;
        end
      end
      ST_LD_CNT: begin
        cmd.ld_cnt = 1'b1;
        state_nxt  = ST_NORM_C;
      end
      ST_NORM_C: begin
        if (status.norm_top) begin
          cmd.man_load = 1'b1;
          itr_nxt      = SQR_LAST_ITR;
          state_nxt    = ST_SQR_C;
        end else begin
          cmd.norm_shift = 1'b1;
        end
      end
      ST_SQR_C: begin
        cmd.sqr_step = 1'b1;
        if (itr_r == '0) begin
          state_nxt = ST_SCALE;
        end else begin
          itr_nxt = itr_r - 1'b1;
        end
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = ST_LEVEL;
      end
      ST_LEVEL: begin
        cmd.set_level = 1'b1;
        state_nxt     = ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        itr_nxt      = DIV_LAST_ITR;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (itr_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          itr_nxt = itr_r - 1'b1;
        end
      end
      ST_DONE: begin
        // hold the result until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_ACCUM;
        end
      end
      default: begin
        state_nxt = ST_ACCUM;
      end
    endcase
    out_valid_nxt = (out_valid_r && !out_ready) || cmd.finish;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACCUM;
      itr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      itr_r       <= itr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_ACCUM);
  assign out_valid = out_valid_r;

  // a window end's last sample moves the sequencer from accumulation to ST_ADD
  a_end_leaves_accum: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.acc && status.last) |=> (state_r == ST_ADD))
    else $error("window end did not start the level computation");

  a_finish_frees_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r)
    else $error("result lost on finish");

  a_div_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (itr_r <= DIV_LAST_ITR))
    else $error("divider step counter out of range");

endmodule

/* design/rdlm_datapath.sv */
// rdlm_datapath: square-sum accumulator, shared normaliser and squaring log2
// unit, dB scaling multiplier, clamp and meter divider; uses rdlm_pkg
`timescale 1ns / 1ps

module rdlm_datapath import rdlm_pkg::*; #(
  parameter int METER_CELLS = 20
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cmd_t                        cmd,
  output status_t                     status,
  input  logic signed [SAMPLE_W-1:0]  in_sample,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  output logic signed [LEVEL_W-1:0]   out_level,
  output logic [BAR_W-1:0]            out_bar_length
);

  localparam int CW    = $clog2(METER_CELLS + 1);
  localparam int REM_W = LEVEL_W + CW;

  logic [CNT_W-1:0]            wlen_r;
  logic [FLOOR_W-1:0]          floor_r;
  logic [SQ_W-1:0]             sq_r;
  logic                        sq_v_r;
  logic [SUM_W-1:0]            sum_r, sum_nxt;
  logic [CNT_W-1:0]            cnt_r;
  logic [SUM_W-1:0]            norm_r;
  logic [EXP_W-1:0]            exp_r;
  logic [MAN_W-1:0]            man_r;
  logic [FRAC_W-1:0]           frac_r;
  logic [LOG_W-1:0]            log_sum_r;
  logic [PROD_W-1:0]           prod_r;
  logic                        neg_r;
  logic signed [LEVEL_W-1:0]   level_r, level_nxt;
  logic [REM_W-1:0]            rem_r, dsh_r;
  logic [CW-1:0]               quo_r;
  logic [LEVEL_W-1:0]          out_level_r;
  logic [CW-1:0]               out_bar_r;

  logic [CNT_W-1:0]            wl_eff;
  logic [CNT_W:0]              cnt_inc;
  logic [FLOOR_W-1:0]          floor_eff, floor_mag;
  logic [LEVEL_W-1:0]          div;
  logic signed [2*SAMPLE_W-1:0] sq_full;
  logic [2*MAN_W-1:0]          man_sq;
  logic [MAN_W:0]              sq_top;
  logic [LOG_W:0]              d, d_neg;
  logic [LOG_W-1:0]            mag;
  logic [PROD_W-1:0]           scaled;
  logic [PROD_W:0]             rnd;
  logic [R_W-1:0]              r, lvl_mag, lvl_neg;
  logic                        take_neg;
  logic [LEVEL_W:0]            span;
  logic                        ge;

  // window length 0 acts as 1, a floor of 0 or above acts as -1 dB
  assign wl_eff    = (wlen_r == '0) ? CNT_W'(1) : wlen_r;
  assign cnt_inc   = {1'b0, cnt_r} + 1'b1;
  assign floor_eff = floor_r[FLOOR_W-1] ? floor_r : '1;
  assign floor_mag = -floor_eff;
  assign div       = {floor_mag, 8'h00};   // -floor in 1/256 dB

  assign sq_full = in_sample * in_sample;
  assign sum_nxt = sum_r + SUM_W'(sq_r);

  assign man_sq = man_r * man_r;
  assign sq_top = man_sq[2*MAN_W-1 -: MAN_W+1];

  // log2(sum) - log2(count) - 30, q16
  assign d      = {1'b0, log_sum_r} - {1'b0, exp_r, frac_r} - LOG_OFFSET;
  assign d_neg  = -d;
  assign mag    = d[LOG_W] ? d_neg[LOG_W-1:0] : d[LOG_W-1:0];
  assign scaled = mag * DB_PER_LOG2;

  // round half away from zero on the magnitude, then clamp to [floor, 0]
  assign rnd      = {1'b0, prod_r} + RND_HALF;
  assign r        = rnd[PROD_W -: R_W];
  assign lvl_mag  = cmd.silent ? R_W'(div) :
                    ((r > R_W'(div)) ? R_W'(div) : r);
  assign lvl_neg  = -lvl_mag;
  assign take_neg = cmd.silent || neg_r;
  assign level_nxt = take_neg ? lvl_neg[LEVEL_W-1:0] : '0;

  assign span = {level_r[LEVEL_W-1], level_r} + {1'b0, div};
  assign ge   = (rem_r >= dsh_r);

  assign status.last     = (cnt_inc >= {1'b0, wl_eff});
  assign status.sum_zero = (sum_r == '0);
  assign status.norm_top = norm_r[SUM_W-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r  <= WINDOW_LEN_RST;
      floor_r <= FLOOR_DB_RST;
      sum_r   <= '0;
      cnt_r   <= '0;
      sq_v_r  <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_WINDOW_LEN) begin
        wlen_r <= cfg_data;
      end
      if (cfg_we && cfg_index == CFG_FLOOR_DB) begin
        floor_r <= cfg_data[FLOOR_W-1:0];
      end
      sq_v_r <= cmd.acc;
      if (cmd.finish) begin
        sum_r <= '0;
        cnt_r <= '0;
      end else begin
        if (sq_v_r) begin
          sum_r <= sum_nxt;
        end
        if (cmd.acc) begin
          cnt_r <= cnt_inc[CNT_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      sq_r <= sq_full[SQ_W-1:0];
    end
    if (cmd.ld_sum) begin
      norm_r <= sum_r;
      exp_r  <= EXP_TOP;
    end else if (cmd.ld_cnt) begin
      log_sum_r <= {exp_r, frac_r};
      norm_r    <= SUM_W'(cnt_r);
      exp_r     <= EXP_TOP;
    end else if (cmd.norm_shift) begin
      norm_r <= {norm_r[SUM_W-2:0], 1'b0};
      exp_r  <= exp_r - 1'b1;
    end
    if (cmd.man_load) begin
      man_r  <= norm_r[SUM_W-1 -: MAN_W];
      frac_r <= '0;
    end else if (cmd.sqr_step) begin
      // one fraction bit per squaring
      man_r  <= sq_top[MAN_W] ? sq_top[MAN_W:1] : sq_top[MAN_W-1:0];
      frac_r <= {frac_r[FRAC_W-2:0], sq_top[MAN_W]};
    end
    if (cmd.scale) begin
      prod_r <= scaled;
      neg_r  <= d[LOG_W];
    end
    if (cmd.set_level) begin
      level_r <= level_nxt;
    end
    if (cmd.div_init) begin
      rem_r <= REM_W'(span[LEVEL_W-1:0]) * REM_W'(METER_CELLS);
      dsh_r <= REM_W'(div) << (CW - 1);
      quo_r <= '0;
    end else if (cmd.div_step) begin
      if (ge) begin
        rem_r <= rem_r - dsh_r;
      end
      dsh_r <= dsh_r >> 1;
      quo_r <= CW'({quo_r, ge});
    end
    if (cmd.finish) begin
      out_level_r <= level_r;
      out_bar_r   <= quo_r;
    end
  end

  assign out_level      = out_level_r;
  assign out_bar_length = BAR_W'(out_bar_r);

  a_last_square_in: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_sum |-> !sq_v_r)
    else $error("log started before the last square was summed");

  a_norm_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.norm_shift |-> (exp_r != '0 && norm_r != '0))
    else $error("normaliser shifted past bit zero");

  a_man_normalised: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sqr_step |-> man_r[MAN_W-1])
    else $error("mantissa left its normal range");

  a_level_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_init |-> (!span[LEVEL_W] && span[LEVEL_W-1:0] <= div))
    else $error("level outside floor to zero");

  a_bar_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (quo_r <= CW'(METER_CELLS)))
    else $error("meter length beyond the cell count");

endmodule

/* design/rms_decibel_level_meter_unit.sv */
// rms_decibel_level_meter_unit: top level of the dBFS level meter, joins the
// sequencer and the datapath; uses rdlm_pkg, rdlm_ctrl, rdlm_datapath
`timescale 1ns / 1ps

// Takes one signed Q1.15 sample per cycle and sums the squares over window_len
// samples. A window's last sample starts the level computation and input stays
// stalled until it is done: a shared shift normaliser (one bit a cycle) and a
// 16-step squaring log2 unit run first on the square sum, then on the sample
// count, followed by one dB scaling multiply, a clamp step and a restoring
// divider of clog2(METER_CELLS+1) steps for the meter length. A window with a
// zero square sum skips the log and the multiply and goes straight to the
// clamp and the divider. Either may also wait for an earlier result still
// held in the output register. Configuration writes are always taken;
// cfg_index 0 is window_len, 1 is floor_db.

module rms_decibel_level_meter_unit import rdlm_pkg::*; #(
  parameter int METER_CELLS = 20
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [SAMPLE_W-1:0]  in_sample,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [LEVEL_W-1:0]   out_level,
  output logic [BAR_W-1:0]            out_bar_length,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data
);

  localparam int DIV_STEPS = $clog2(METER_CELLS + 1);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  rdlm_ctrl #(
    .DivSteps (DIV_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  rdlm_datapath #(
    .METER_CELLS (METER_CELLS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_sample      (in_sample),
    .cfg_we         (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_level      (out_level),
    .out_bar_length (out_bar_length)
  );

endmodule

/* dv/tb_rms_decibel_level_meter_unit.sv */
// tb_rms_decibel_level_meter_unit: self-checking bench for the dBFS level meter,
// predicts every window reading from the accepted samples and checks the output
// depends on rdlm_pkg and rms_decibel_level_meter_unit
`timescale 1ns / 1ps

module tb_rms_decibel_level_meter_unit;
  import rdlm_pkg::*;

  localparam int     CELLS        = 20;
  localparam longint DB_STEP_Q32  = 64'd50504453;   // 10*log10(2) in q24
  localparam int     WIND_DOWN    = 200;
  localparam int     CYCLE_LIMIT  = 3_000_000;
  localparam int     RANDOM_ITEMS = 900;
  localparam int     FULL_WINDOW  = 300;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 4'd9;

  localparam logic signed [SAMPLE_W-1:0] MOST_POS = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] MOST_NEG = 16'sh8000;

  typedef struct packed {
    logic signed [LEVEL_W-1:0] level;
    logic [BAR_W-1:0]          bar;
  } reading_t;

  logic                       clk       = 1'b0;
  logic                       rst_n     = 1'b0;
  logic                       in_valid  = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_sample = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [LEVEL_W-1:0]  out_level;
  logic [BAR_W-1:0]           out_bar_length;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_data  = '0;

  logic signed [SAMPLE_W-1:0] samples_pending[$];
  reading_t                   readings_due[$];

  // predicted state of the meter
  logic [SUM_W-1:0]          sq_sum;
  logic [CNT_W-1:0]          n_seen;
  logic [CNT_W-1:0]          win_len;
  logic signed [FLOOR_W-1:0] floor_set;

  int feed_gap  = 0;
  bit fast_feed = 1'b0;
  int hold_left = 0;
  int fails     = 0;
  int cycles    = 0;

  rms_decibel_level_meter_unit #(
    .METER_CELLS(CELLS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample     (in_sample),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_level     (out_level),
    .out_bar_length(out_bar_length),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int idle_span();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    else if (pick < 85) return $urandom_range(1, 3);
    else if (pick < 97) return $urandom_range(4, 10);
    else return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] shaped_sample(input int shift);
    logic signed [SAMPLE_W-1:0] raw;
    raw = SAMPLE_W'($urandom);
    return raw >>> shift;
  endfunction

  // log2 with 16 fractional bits: normalise, then square and keep the top bit
  function automatic longint fixed_log2(input logic [63:0] x);
    int          e;
    logic [63:0] m;
    logic [15:0] fr;
    e = 63;
    while (e > 0 && x[e] == 1'b0) e--;
    m = (e >= 30) ? (x >> (e - 30)) : (x << (30 - e));
    fr = '0;
    for (int i = 15; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= 64'h8000_0000) begin
        m = m >> 1;
        fr[i] = 1'b1;
      end
    end
    return longint'(e) * 65536 + longint'(fr);
  endfunction

  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_WINDOW_LEN: win_len = val;
      CFG_FLOOR_DB:   floor_set = val[FLOOR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic integrate_sample(input logic signed [SAMPLE_W-1:0] s);
    int          limit;
    int          cnt;
    longint      lo;
    longint      d;
    longint      lvl;
    longint      bar_len;
    logic [63:0] mag;
    logic [63:0] prod;
    logic [63:0] rnd;
    reading_t    r;
    limit = (win_len == 0) ? 1 : int'(win_len);
    sq_sum = sq_sum + SUM_W'(longint'(s) * longint'(s));
    cnt = int'(n_seen) + 1;
    if (cnt < limit) begin
      n_seen = CNT_W'(cnt);
      return;
    end
    // a floor of zero or above behaves as -1 dB
    lo = (floor_set < 0) ? longint'(floor_set) * 256 : -256;
    if (sq_sum == 0) begin
      lvl = lo;
    end else begin
      // the window's actual count is the divisor, also when it was cut short
      d = fixed_log2(64'(sq_sum)) - fixed_log2(64'(cnt)) - 30 * 65536;
      mag = (d < 0) ? 64'(-d) : 64'(d);
      prod = mag * DB_STEP_Q32;
      rnd = (prod + 64'h8000_0000) >> 32;
      lvl = (d < 0) ? -longint'(rnd) : longint'(rnd);
      if (lvl > 0) lvl = 0;
      if (lvl < lo) lvl = lo;
    end
    bar_len = ((lvl - lo) * CELLS) / (-lo);
    r.level = LEVEL_W'(lvl);
    r.bar = BAR_W'(bar_len);
    readings_due.push_back(r);
    sq_sum = '0;
    n_seen = '0;
  endtask

  // sample driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (feed_gap > 0) begin
        feed_gap--;
        in_valid <= 1'b0;
      end else if (samples_pending.size() != 0) begin
        in_sample <= samples_pending.pop_front();
        in_valid <= 1'b1;
        feed_gap = fast_feed ? 0 : idle_span();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result back-pressure, with the odd long run of ready
  always @(posedge clk) begin
    int stall;
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left = 0;
    end else if (hold_left > 0) begin
      hold_left--;
    end else if (out_ready) begin
      stall = idle_span();
      if (stall > 0) begin
        out_ready <= 1'b0;
        hold_left = stall - 1;
      end else begin
        hold_left = $urandom_range(0, 10);
      end
    end else begin
      out_ready <= 1'b1;
      hold_left = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(0, 15);
    end
  end

  // prediction on every transfer in, comparison on every transfer out
  always @(posedge clk) begin
    reading_t got;
    reading_t want;
    if (!rst_n) begin
      sq_sum = '0;
      n_seen = '0;
      win_len = 16'd1470;
      floor_set = -8'sd60;
    end else begin
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) integrate_sample(in_sample);
      if (out_valid && out_ready) begin
        got.level = out_level;
        got.bar = out_bar_length;
        if (readings_due.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("unexpected reading: level %0d bar %0d", got.level, got.bar);
        end else begin
          want = readings_due.pop_front();
          if (got !== want) begin
            fails++;
            if (fails <= 10)
              $display("reading mismatch: level %0d (expected %0d), bar %0d (expected %0d)",
                       got.level, want.level, got.bar, want.bar);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // wait for all samples and readings, then let a final level computation finish
  task automatic settle();
    do @(negedge clk);
    while (samples_pending.size() != 0 || in_valid || readings_due.size() != 0);
    repeat (WIND_DOWN) @(posedge clk);
  endtask

  initial begin
    logic signed [SAMPLE_W-1:0] opening [16];
    logic signed [FLOOR_W-1:0]  fl;
    int  total;
    int  pick;
    int  wl_pick;
    int  eff;
    int  nwin;
    int  extra;
    int  sh;
    bit  silent;

    opening = '{MOST_POS, MOST_NEG, 16'sd0, -16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG, 16'sd1, 16'sd1, 16'sd1, 16'sd1};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // full scale both ways, a silent window, full scale clamped at 0, near silence
    write_reg(CFG_WINDOW_LEN, 16'd4);
    write_reg(CFG_FLOOR_DB, 16'hFFC4);
    @(negedge clk);
    foreach (opening[i]) samples_pending.push_back(opening[i]);

    // zero window length acts as one, a floor of zero acts as -1 dB
    settle();
    write_reg(CFG_WINDOW_LEN, 16'd0);
    write_reg(CFG_FLOOR_DB, 16'h0000);
    @(negedge clk);
    samples_pending.push_back(16'sd100);
    samples_pending.push_back(MOST_NEG);
    samples_pending.push_back(16'sd0);

    // floor at its lowest
    settle();
    write_reg(CFG_FLOOR_DB, 16'h0080);
    write_reg(CFG_SPARE, 16'hA5A5);
    @(negedge clk);
    samples_pending.push_back(16'sd1);
    samples_pending.push_back(16'sd16384);

    // window cut short part way through
    settle();
    write_reg(CFG_WINDOW_LEN, 16'hFFFF);
    @(negedge clk);
    repeat (3) samples_pending.push_back(shaped_sample(0));
    settle();
    write_reg(CFG_WINDOW_LEN, 16'd2);
    @(negedge clk);
    samples_pending.push_back(shaped_sample(0));

    // one long window, mostly at full scale
    settle();
    write_reg(CFG_WINDOW_LEN, CFG_DATA_W'(FULL_WINDOW));
    write_reg(CFG_FLOOR_DB, 16'h5588);
    @(negedge clk);
    fast_feed = 1'b1;
    for (int k = 0; k < FULL_WINDOW; k++) begin
      if ($urandom_range(0, 7) == 0) samples_pending.push_back(shaped_sample(0));
      else samples_pending.push_back($urandom_range(0, 1) ? MOST_NEG : MOST_POS);
    end

    total = 0;
    while (total < RANDOM_ITEMS) begin
      settle();
      pick = $urandom_range(0, 9);
      if (pick < 6) wl_pick = $urandom_range(1, 8);
      else if (pick < 8) wl_pick = $urandom_range(9, 64);
      else if (pick == 8) wl_pick = $urandom_range(65, 400);
      else wl_pick = 0;
      write_reg(CFG_WINDOW_LEN, CFG_DATA_W'(wl_pick));

      pick = $urandom_range(0, 19);
      if (pick < 14) fl = -8'($urandom_range(1, 120));
      else if (pick < 17) fl = -8'($urandom_range(121, 128));
      else fl = 8'($urandom);
      if ($urandom_range(0, 4) != 0) write_reg(CFG_FLOOR_DB, {8'($urandom), fl});
      if ($urandom_range(0, 7) == 0)
        write_reg(CFG_IDX_W'($urandom_range(2, 15)), 16'($urandom));

      eff = (wl_pick == 0) ? 1 : wl_pick;
      nwin = (eff > 64) ? 1 : $urandom_range(1, 6);
      // a leftover part window carries into the next setting
      extra = ($urandom_range(0, 2) == 0) ? $urandom_range(1, eff) : 0;
      @(negedge clk);
      fast_feed = ($urandom_range(0, 4) == 0);
      for (int w = 0; w < nwin; w++) begin
        silent = ($urandom_range(0, 15) == 0);
        sh = $urandom_range(0, 15);
        for (int k = 0; k < eff; k++)
          samples_pending.push_back(silent ? 16'sd0 : shaped_sample(sh));
      end
      for (int k = 0; k < extra; k++)
        samples_pending.push_back(shaped_sample($urandom_range(0, 15)));
      total += nwin * eff + extra;
    end

    settle();
    if (fails == 0 && readings_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
